/* hw/rtl/qpy_pkg.sv */
// ============================================================================
// qpy_pkg: shared constants for the quaternion to pitch/yaw converter
// Widths of the fixed-point datapath, CORDIC stage count and angle table.
// ============================================================================
package qpy_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int ATAN_TAB_LEN   = 24;
    localparam int NUM_STAGES     = (CORDIC_STAGES > ATAN_TAB_LEN) ? ATAN_TAB_LEN
                                                                   : CORDIC_STAGES;

    localparam int QUAT_W         = 16;   // Q1.14 input component
    localparam int PROD_W         = 32;   // exact 16x16 product
    localparam int ARG_W          = 34;   // atan2 arguments at scale 2^28
    localparam int CRD_W          = 36;   // CORDIC x/y with gain headroom
    localparam int ANG_W          = 25;   // angle accumulator at scale 2^20
    localparam int OUT_W          = 16;   // Q2.13 output angle
    localparam int ANG_FRAC_SHIFT = 7;
    localparam int RND_W          = ANG_W + 1 - ANG_FRAC_SHIFT;
    localparam int ANG_LIMIT      = 25736;
    localparam int PIPE_DEPTH     = NUM_STAGES + 4;

    localparam logic signed [ANG_W-1:0] HALF_PI_S20 = ANG_W'(1647099);
    localparam logic signed [ARG_W-1:0] ONE_S28     = ARG_W'(1) <<< 28;

    typedef struct packed {
        logic en;
        logic negate;
    } t_atan_ctrl;

    // round(atan(2^-i) * 2^20)
    function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
        case (idx)
            0:  return ANG_W'(823550);
            1:  return ANG_W'(486170);
            2:  return ANG_W'(256879);
            3:  return ANG_W'(130396);
            4:  return ANG_W'(65451);
            5:  return ANG_W'(32757);
            6:  return ANG_W'(16383);
            7:  return ANG_W'(8192);
            8:  return ANG_W'(4096);
            9:  return ANG_W'(2048);
            10: return ANG_W'(1024);
            11: return ANG_W'(512);
            12: return ANG_W'(256);
            13: return ANG_W'(128);
            14: return ANG_W'(64);
            15: return ANG_W'(32);
            16: return ANG_W'(16);
            17: return ANG_W'(8);
            18: return ANG_W'(4);
            19: return ANG_W'(2);
            20: return ANG_W'(1);
            default: return '0;
        endcase
    endfunction

endpackage

/* hw/rtl/qpy_atan2.sv */
// ============================================================================
// qpy_atan2: pipelined CORDIC atan2
// Quadrant pre-rotation, one register stage per CORDIC iteration, then
// rounding to Q2.13, clamping and optional negation in the output register.
// ============================================================================
module qpy_atan2
    import qpy_pkg::*;
(
    input  logic                     i_clk,
    input  t_atan_ctrl               i_ctrl,
    input  logic signed [ARG_W-1:0]  i_num,
    input  logic signed [ARG_W-1:0]  i_den,
    output logic signed [OUT_W-1:0]  o_angle
);

    logic signed [CRD_W-1:0] r_cx   [0:NUM_STAGES];
    logic signed [CRD_W-1:0] r_cy   [0:NUM_STAGES];
    logic signed [ANG_W-1:0] r_a    [0:NUM_STAGES];
    logic                    r_zero [0:NUM_STAGES];
    logic signed [OUT_W-1:0] r_angle;

    logic signed [CRD_W-1:0] num_e;
    logic signed [CRD_W-1:0] den_e;
    logic signed [CRD_W-1:0] n_cx;
    logic signed [CRD_W-1:0] n_cy;
    logic signed [ANG_W-1:0] n_a;

    assign num_e = CRD_W'(i_num);
    assign den_e = CRD_W'(i_den);

    // A vector in the left half plane is turned by a quarter turn first.
    always_comb begin
        if (i_den < 0) begin
            if (i_num >= 0) begin
                n_cx = num_e;
                n_cy = -den_e;
                n_a  = HALF_PI_S20;
            end else begin
                n_cx = -num_e;
                n_cy = den_e;
                n_a  = -HALF_PI_S20;
            end
        end else begin
            n_cx = den_e;
            n_cy = num_e;
            n_a  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_cx[0]   <= n_cx;
            r_cy[0]   <= n_cy;
            r_a[0]    <= n_a;
            r_zero[0] <= (i_num == '0) && (i_den == '0);
        end
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        logic signed [CRD_W-1:0] dx;
        logic signed [CRD_W-1:0] dy;

        assign dx = r_cy[g] >>> g;
        assign dy = r_cx[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (i_ctrl.en) begin
                if (r_cy[g] >= 0) begin
                    r_cx[g+1] <= r_cx[g] + dx;
                    r_cy[g+1] <= r_cy[g] - dy;
                    r_a[g+1]  <= r_a[g] + atan_tab(g);
                end else begin
                    r_cx[g+1] <= r_cx[g] - dx;
                    r_cy[g+1] <= r_cy[g] + dy;
                    r_a[g+1]  <= r_a[g] - atan_tab(g);
                end
                r_zero[g+1] <= r_zero[g];
            end
        end
    end

    localparam logic signed [ANG_W:0]   RND_BIAS = (ANG_W+1)'(1) <<< (ANG_FRAC_SHIFT - 1);
    localparam logic signed [RND_W-1:0] LIM_POS  = RND_W'(ANG_LIMIT);
    localparam logic signed [RND_W-1:0] LIM_NEG  = -LIM_POS;

    logic signed [ANG_W:0]   a_biased;
    logic signed [ANG_W:0]   a_shift;
    logic signed [RND_W-1:0] a_rnd;
    logic signed [OUT_W-1:0] a_clamp;
    logic signed [OUT_W-1:0] n_angle;

    always_comb begin
        a_biased = (ANG_W+1)'(r_a[NUM_STAGES]) + RND_BIAS;
        a_shift  = a_biased >>> ANG_FRAC_SHIFT;
        a_rnd    = a_shift[RND_W-1:0];
        if (r_zero[NUM_STAGES]) begin
            a_clamp = '0;
        end else if (a_rnd > LIM_POS) begin
            a_clamp = OUT_W'(LIM_POS);
        end else if (a_rnd < LIM_NEG) begin
            a_clamp = OUT_W'(LIM_NEG);
        end else begin
            a_clamp = a_rnd[OUT_W-1:0];
        end
        n_angle = i_ctrl.negate ? -a_clamp : a_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

/* hw/rtl/quaternion_to_pitch_yaw.sv */
// ============================================================================
// quaternion_to_pitch_yaw: orientation quaternion to pitch and yaw angles
// Exact fixed-point products form both atan2 arguments; two CORDIC pipelines
// resolve pitch (roll about sensor X) and yaw (rotation about sensor Z).
// ============================================================================
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[63:0] = quat_w, quat_x, quat_y, quat_z (Q1.14)
//  m_axis    out        tdata[31:0] = pitch_angle, yaw_angle (Q2.13 rad)
//  APB       in/out     0x0 pitch_negate, 0x4 yaw_negate (bit 0)
//
//  One quaternion is taken every cycle while m_axis is not held off; its
//  result passes through the product stage, the sum stage, the pre-rotation
//  stage, one stage per CORDIC iteration and the output register. When
//  m_axis is held off, the whole pipeline freezes and s_axis_tready drops.
//  Reset clears the valid bits and both negate bits.
//
module quaternion_to_pitch_yaw
    import qpy_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z from bit 0
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pitch_angle, yaw_angle from bit 0
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_PITCH_NEG = 1'b0;
    localparam logic REG_YAW_NEG   = 1'b1;

    logic r_pitch_neg;
    logic r_yaw_neg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_neg <= 1'b0;
            r_yaw_neg   <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PITCH_NEG) begin
                r_pitch_neg <= pwdata[0];
            end
            if (paddr[2] == REG_YAW_NEG) begin
                r_yaw_neg <= pwdata[0];
            end
        end
    end

    assign prdata = {31'b0, (paddr[2] == REG_YAW_NEG) ? r_yaw_neg : r_pitch_neg};

    // The pipeline moves as one whenever the output register can be refilled.
    logic                  advance;
    logic [PIPE_DEPTH-1:0] r_valid;

    assign advance       = !r_valid[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = r_valid[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (advance) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    logic signed [QUAT_W-1:0] qw, qx, qy, qz;

    assign qw = $signed(s_axis_tdata[15:0]);
    assign qx = $signed(s_axis_tdata[31:16]);
    assign qy = $signed(s_axis_tdata[47:32]);
    assign qz = $signed(s_axis_tdata[63:48]);

    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
        end
    end

    logic signed [ARG_W-1:0] r_p_num, r_p_den, r_y_num, r_y_den;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p_num <= (ARG_W'(r_wx) + ARG_W'(r_yz)) <<< 1;
            r_p_den <= ONE_S28 - ((ARG_W'(r_xx) + ARG_W'(r_yy)) <<< 1);
            r_y_num <= (ARG_W'(r_wz) + ARG_W'(r_xy)) <<< 1;
            r_y_den <= ONE_S28 - ((ARG_W'(r_yy) + ARG_W'(r_zz)) <<< 1);
        end
    end

    t_atan_ctrl              pitch_ctrl;
    t_atan_ctrl              yaw_ctrl;
    logic signed [OUT_W-1:0] pitch_angle;
    logic signed [OUT_W-1:0] yaw_angle;

    assign pitch_ctrl = '{en: advance, negate: r_pitch_neg};
    assign yaw_ctrl   = '{en: advance, negate: r_yaw_neg};

    qpy_atan2 u_pitch (
        .i_clk   (i_clk),
        .i_ctrl  (pitch_ctrl),
        .i_num   (r_p_num),
        .i_den   (r_p_den),
        .o_angle (pitch_angle)
    );

    qpy_atan2 u_yaw (
        .i_clk   (i_clk),
        .i_ctrl  (yaw_ctrl),
        .i_num   (r_y_num),
        .i_den   (r_y_den),
        .o_angle (yaw_angle)
    );

    assign m_axis_tdata = {yaw_angle, pitch_angle};

endmodule

/* hw/rtl/qpy_checker.sv */
// ============================================================================
// qpy_port_checks: port-level checks for the quaternion to pitch/yaw converter
// Watches the stream and register ports of the top level over time.
// ============================================================================
module qpy_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A result that is held off stays on the bus unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result changed or vanished");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Both angles stay within -pi..pi in Q2.13.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[15:0]) <= 16'sd25736) &&
            ($signed(m_axis_tdata[15:0]) >= -16'sd25736) &&
            ($signed(m_axis_tdata[31:16]) <= 16'sd25736) &&
            ($signed(m_axis_tdata[31:16]) >= -16'sd25736))
        else $error("angle out of range");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A written negate bit reads back at once.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && pready) &&
        (paddr[2] == $past(paddr[2])) |-> prdata[0] == $past(pwdata[0]))
        else $error("register readback mismatch");

endmodule

bind quaternion_to_pitch_yaw qpy_port_checks u_qpy_port_checks (.*);
